>>> design/urx_pkg.sv
// ----------------------------------------------------------------------------
// urx_pkg
// Shared types and constants for the receive chunker: event and mode codes,
// register indexes, queue sizing and the command beat format.
// ----------------------------------------------------------------------------
package urx_pkg;

   // chunk size and byte store sizing
   localparam int BUF_SIZE    = 64;
   localparam int QUEUE_CAP   = 2 * BUF_SIZE;
   localparam int STORE_DEPTH = 128;
   localparam int PTR_W       = $clog2(STORE_DEPTH);
   localparam int FILL_W      = $clog2(QUEUE_CAP + 1);
   localparam int CHUNK_W     = $clog2(BUF_SIZE + 1);

   // register field widths
   localparam int MODE_W    = 2;
   localparam int TIMEOUT_W = 16;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DAT_W = 16;
   localparam int BYTE_W    = 8;

   localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = TIMEOUT_W'(250);

   // command queue sizing
   localparam int CMD_DEPTH = 2;
   localparam int CMD_PTR_W = $clog2(CMD_DEPTH);
   localparam int CMD_CNT_W = $clog2(CMD_DEPTH + 1);

   // input event codes
   localparam logic [1:0] EV_BYTE  = 2'd0;
   localparam logic [1:0] EV_TICK  = 2'd1;
   localparam logic [1:0] EV_CLEAR = 2'd2;

   // data mode codes
   localparam logic [MODE_W-1:0] DM_IGNORE = MODE_W'(0);
   localparam logic [MODE_W-1:0] DM_PASS   = MODE_W'(1);
   localparam logic [MODE_W-1:0] DM_BUFFER = MODE_W'(2);

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_DATA_MODE = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_FLUSH_EN  = CSR_IDX_W'(1);
   localparam logic [CSR_IDX_W-1:0] CSR_TIMEOUT   = CSR_IDX_W'(2);

   // work handed from front to back
   typedef enum logic [1:0] {
      CMD_STORE,
      CMD_PASS,
      CMD_TICK,
      CMD_CLEAR
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type        kind;
      logic [BYTE_W-1:0]   data;
   } cmd_type;

   // configuration seen by the back end
   typedef struct packed {
      logic                 flush_en;
      logic [TIMEOUT_W-1:0] timeout;
      logic                 queue_clear;
   } cfg_type;

endpackage

>>> design/urx_front.sv
// ----------------------------------------------------------------------------
// urx_front
// Accepts input beats and classifies them into back-end commands; beats that
// have no effect are dropped here.
// ----------------------------------------------------------------------------
module urx_front import urx_pkg::*; (
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [1:0]          req_mode,
   input  logic [BYTE_W-1:0]   req_rx_byte,
   input  logic [MODE_W-1:0]   data_mode,
   input  logic                cmd_full,
   output logic                cmd_push,
   output cmd_type             cmd_data
);

   logic keep;

   // accept whenever the command queue has room
   assign req_ready = ~cmd_full;

   // event decode
   always_comb begin
      keep          = 1'b0;
      cmd_data.kind = CMD_TICK;
      cmd_data.data = req_rx_byte;
      unique case (req_mode)
         EV_BYTE: begin
            if (data_mode == DM_PASS) begin
               keep          = 1'b1;
               cmd_data.kind = CMD_PASS;
            end else if (data_mode == DM_BUFFER) begin
               keep          = 1'b1;
               cmd_data.kind = CMD_STORE;
            end
         end
         EV_TICK: begin
            keep          = 1'b1;
            cmd_data.kind = CMD_TICK;
         end
         EV_CLEAR: begin
            keep          = 1'b1;
            cmd_data.kind = CMD_CLEAR;
         end
         default: keep = 1'b0;
      endcase
   end

   assign cmd_push = req_valid & req_ready & keep & ~reset;

endmodule

>>> design/urx_cmd_fifo.sv
// ----------------------------------------------------------------------------
// urx_cmd_fifo
// Short command queue between the front and back ends.
// ----------------------------------------------------------------------------
module urx_cmd_fifo import urx_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  cmd_type push_data,
   output logic    full,
   output logic    pop_valid,
   input  logic    pop,
   output cmd_type pop_data
);

   cmd_type                entry_ff [CMD_DEPTH];
   logic [CMD_PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [CMD_PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CMD_CNT_W-1:0]   count_ff, count_in;
   logic                   do_push, do_pop;

   assign full      = (count_ff == CMD_CNT_W'(CMD_DEPTH));
   assign pop_valid = (count_ff != '0);
   assign pop_data  = entry_ff[rd_ptr_ff];
   assign do_push   = push & ~full;
   assign do_pop    = pop & pop_valid;

   // pointer and count update
   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push & ~do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop & ~do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

>>> design/urx_back.sv
// ----------------------------------------------------------------------------
// urx_back
// Executes commands: byte store, idle timer, chunk flush from the store and
// the result register.
// ----------------------------------------------------------------------------
module urx_back import urx_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  cfg_type             cfg,
   input  logic                cmd_valid,
   input  cmd_type             cmd_data,
   output logic                cmd_pop,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [BYTE_W-1:0]   rsp_out_byte,
   output logic                rsp_is_chunk,
   output logic                rsp_last
);

   // byte store
   logic [BYTE_W-1:0]    store_mem [STORE_DEPTH];
   logic [BYTE_W-1:0]    rd_data_ff;

   // queue and timer state
   logic [PTR_W-1:0]     rp_ff, rp_in;
   logic [FILL_W-1:0]    fill_ff, fill_in;
   logic [TIMEOUT_W-1:0] timer_ff, timer_in;
   logic                 armed_ff, armed_in;

   // flush sequencing
   logic [PTR_W-1:0]     flush_ptr_ff, flush_ptr_in;
   logic [CHUNK_W-1:0]   remain_ff, remain_in;
   logic                 rd_pend_ff, rd_pend_in;
   logic                 rd_last_ff, rd_last_in;

   // result register
   logic                 out_valid_ff, out_valid_in;
   logic [BYTE_W-1:0]    out_byte_ff, out_byte_in;
   logic                 out_chunk_ff, out_chunk_in;
   logic                 out_last_ff, out_last_in;

   logic                 busy, out_free, load_out, issue;
   logic                 wr_en;
   logic [PTR_W-1:0]     wr_addr;
   logic [FILL_W-1:0]    fill_inc, fill_left;
   logic [TIMEOUT_W-1:0] timer_dec;
   logic [CHUNK_W-1:0]   chunk_sz;

   function automatic logic [TIMEOUT_W-1:0] timer_load(
      input logic [TIMEOUT_W-1:0] timeout,
      input logic [FILL_W-1:0]    fill
   );
      logic [TIMEOUT_W-1:0] val;
      if ((timeout == '0) || (fill >= FILL_W'(BUF_SIZE))) begin
         val = TIMEOUT_W'(1);
      end else begin
         val = timeout;
      end
      return val;
   endfunction

   assign busy     = (remain_ff != '0) | rd_pend_ff;
   assign out_free = ~out_valid_ff | rsp_ready;
   assign load_out = rd_pend_ff & out_free;
   assign issue    = (remain_ff != '0) & (~rd_pend_ff | load_out);
   assign cmd_pop  = cmd_valid & ~busy & ((cmd_data.kind != CMD_PASS) | out_free);

   assign wr_addr   = rp_ff + fill_ff[PTR_W-1:0];
   assign fill_inc  = fill_ff + 1'b1;
   assign timer_dec = timer_ff - 1'b1;
   assign chunk_sz  = (fill_ff > FILL_W'(BUF_SIZE)) ? CHUNK_W'(BUF_SIZE)
                                                    : CHUNK_W'(fill_ff);
   assign fill_left = fill_ff - FILL_W'(chunk_sz);

   // command execution and timer
   always_comb begin
      rp_in        = rp_ff;
      fill_in      = fill_ff;
      timer_in     = timer_ff;
      armed_in     = armed_ff;
      flush_ptr_in = flush_ptr_ff;
      remain_in    = remain_ff;
      wr_en        = 1'b0;
      if (cmd_pop) begin
         case (cmd_data.kind)
            CMD_STORE: begin
               if (fill_ff < FILL_W'(QUEUE_CAP)) begin
                  wr_en   = 1'b1;
                  fill_in = fill_inc;
                  if (cfg.flush_en && (fill_inc <= FILL_W'(BUF_SIZE))) begin
                     timer_in = timer_load(cfg.timeout, fill_inc);
                     armed_in = 1'b1;
                  end
               end
            end
            CMD_TICK: begin
               if (armed_ff) begin
                  timer_in = timer_dec;
                  if (timer_dec == '0) begin
                     armed_in     = 1'b0;
                     flush_ptr_in = rp_ff;
                     remain_in    = chunk_sz;
                     rp_in        = rp_ff + PTR_W'(chunk_sz);
                     fill_in      = fill_left;
                     if (fill_left != '0) begin
                        timer_in = timer_load(cfg.timeout, fill_left);
                        armed_in = 1'b1;
                     end
                  end
               end
            end
            CMD_CLEAR: begin
               fill_in = '0;
               rp_in   = '0;
            end
            default: ;
         endcase
      end
      // buffer mode write empties the queue
      if (cfg.queue_clear) begin
         fill_in = '0;
         rp_in   = '0;
      end
      // flush read sequencing
      if (issue) begin
         flush_ptr_in = flush_ptr_ff + 1'b1;
         remain_in    = remain_ff - 1'b1;
      end
   end

   // read pipeline and result register
   always_comb begin
      rd_pend_in   = rd_pend_ff;
      rd_last_in   = rd_last_ff;
      out_valid_in = out_valid_ff;
      out_byte_in  = out_byte_ff;
      out_chunk_in = out_chunk_ff;
      out_last_in  = out_last_ff;
      if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
      if (load_out) begin
         out_valid_in = 1'b1;
         out_byte_in  = rd_data_ff;
         out_chunk_in = 1'b1;
         out_last_in  = rd_last_ff;
         rd_pend_in   = 1'b0;
      end
      if (issue) begin
         rd_pend_in = 1'b1;
         rd_last_in = (remain_ff == CHUNK_W'(1));
      end
      if (cmd_pop && (cmd_data.kind == CMD_PASS)) begin
         out_valid_in = 1'b1;
         out_byte_in  = cmd_data.data;
         out_chunk_in = 1'b0;
         out_last_in  = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rp_ff        <= '0;
         fill_ff      <= '0;
         timer_ff     <= '0;
         armed_ff     <= 1'b0;
         flush_ptr_ff <= '0;
         remain_ff    <= '0;
         rd_pend_ff   <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         rp_ff        <= rp_in;
         fill_ff      <= fill_in;
         timer_ff     <= timer_in;
         armed_ff     <= armed_in;
         flush_ptr_ff <= flush_ptr_in;
         remain_ff    <= remain_in;
         rd_pend_ff   <= rd_pend_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      rd_last_ff   <= rd_last_in;
      out_byte_ff  <= out_byte_in;
      out_chunk_ff <= out_chunk_in;
      out_last_ff  <= out_last_in;
   end

   // store write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_mem[wr_addr] <= cmd_data.data;
      end
   end

   // store read port
   always_ff @(posedge clock) begin
      if (issue) begin
         rd_data_ff <= store_mem[flush_ptr_ff];
      end
   end

   assign rsp_valid    = out_valid_ff;
   assign rsp_out_byte = out_byte_ff;
   assign rsp_is_chunk = out_chunk_ff;
   assign rsp_last     = out_last_ff;

endmodule

>>> design/uart_rx_idle_timeout_chunker.sv
// ----------------------------------------------------------------------------
// uart_rx_idle_timeout_chunker
// Receive buffer that passes bytes through, or stores them and flushes them
// in chunks when an idle timer runs out.
// ----------------------------------------------------------------------------
//  channel  ports                        beat
//  req      req_valid / req_ready        event: byte, tick or clear
//  rsp      rsp_valid / rsp_ready        one delivered byte with flags
//  csr      csr_we, csr_index, csr_wdata register write, no wait
//
//  Bytes, ticks and clears are taken one per cycle while the two-entry
//  command queue has room; the back end takes a command only while no flush
//  is running. A flush starts in the cycle after its tick and then sends
//  one byte per cycle through the store read port while rsp_ready is high.
//  A held beat with rsp_ready low stalls flushes and pass bytes; the front keeps
//  accepting until the queue fills. Reset clears control state, not the store.
// ----------------------------------------------------------------------------
module uart_rx_idle_timeout_chunker import urx_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [1:0]             req_mode,
   input  logic [BYTE_W-1:0]      req_rx_byte,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [BYTE_W-1:0]      rsp_out_byte,
   output logic                   rsp_is_chunk,
   output logic                   rsp_last,
   input  logic                   csr_we,
   input  logic [CSR_IDX_W-1:0]   csr_index,
   input  logic [CSR_DAT_W-1:0]   csr_wdata
);

   logic [MODE_W-1:0]    data_mode_ff, data_mode_in;
   logic                 flush_en_ff, flush_en_in;
   logic [TIMEOUT_W-1:0] timeout_ff, timeout_in;
   logic                 queue_clear;
   cfg_type              cfg;

   logic                 cmd_full, cmd_push, cmd_valid, cmd_pop;
   cmd_type              cmd_in, cmd_out;

   // register writes
   always_comb begin
      data_mode_in = data_mode_ff;
      flush_en_in  = flush_en_ff;
      timeout_in   = timeout_ff;
      queue_clear  = 1'b0;
      if (csr_we) begin
         unique case (csr_index)
            CSR_DATA_MODE: begin
               data_mode_in = csr_wdata[MODE_W-1:0];
               if (csr_wdata[MODE_W-1:0] == DM_BUFFER) begin
                  queue_clear = 1'b1;
               end else if (csr_wdata[MODE_W-1:0] == DM_PASS) begin
                  flush_en_in = 1'b0;
               end
            end
            CSR_FLUSH_EN: flush_en_in = csr_wdata[0];
            CSR_TIMEOUT:  timeout_in  = csr_wdata[TIMEOUT_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         data_mode_ff <= DM_IGNORE;
         flush_en_ff  <= 1'b0;
         timeout_ff   <= TIMEOUT_RESET;
      end else begin
         data_mode_ff <= data_mode_in;
         flush_en_ff  <= flush_en_in;
         timeout_ff   <= timeout_in;
      end
   end

   assign cfg.flush_en    = flush_en_ff;
   assign cfg.timeout     = timeout_ff;
   assign cfg.queue_clear = queue_clear & ~reset;

   urx_front u_front (
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_mode    (req_mode),
      .req_rx_byte (req_rx_byte),
      .data_mode   (data_mode_ff),
      .cmd_full    (cmd_full),
      .cmd_push    (cmd_push),
      .cmd_data    (cmd_in)
   );

   urx_cmd_fifo u_cmd_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (cmd_push),
      .push_data (cmd_in),
      .full      (cmd_full),
      .pop_valid (cmd_valid),
      .pop       (cmd_pop),
      .pop_data  (cmd_out)
   );

   urx_back u_back (
      .clock        (clock),
      .reset        (reset),
      .cfg          (cfg),
      .cmd_valid    (cmd_valid),
      .cmd_data     (cmd_out),
      .cmd_pop      (cmd_pop),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_out_byte (rsp_out_byte),
      .rsp_is_chunk (rsp_is_chunk),
      .rsp_last     (rsp_last)
   );

endmodule

>>> tb/urx_tb_pkg.sv
// ----------------------------------------------------------------------------
// urx_tb_pkg
// Scoreboard for the receive chunker bench: keeps a shadow copy of the queue,
// the idle timer and the registers, predicts the delivered beats for every
// accepted event and checks the delivered beats against them in order.
// ----------------------------------------------------------------------------
package urx_tb_pkg;
   import urx_pkg::*;

   // one delivered beat
   typedef struct packed {
      logic [BYTE_W-1:0] data;
      logic              chunk;
      logic              last;
   } rx_beat_type;

   class rx_delivery_scoreboard;
      // shadow of the byte queue and idle timer
      logic [BYTE_W-1:0]    store_mirror [STORE_DEPTH];
      logic [PTR_W-1:0]     head_ptr;
      logic [FILL_W-1:0]    fill;
      logic [TIMEOUT_W-1:0] idle_count;
      logic                 idle_armed;
      // shadow of the registers
      logic [MODE_W-1:0]    data_mode;
      logic                 flush_en;
      logic [TIMEOUT_W-1:0] timeout;
      // beats still owed by the block
      rx_beat_type          due_beats [$];
      int                   mismatches;
      int                   delivered;
      int                   chunk_beats;
      int                   chunks;
      int                   dropped;

      function new();
         mismatches  = 0;
         delivered   = 0;
         chunk_beats = 0;
         chunks      = 0;
         dropped     = 0;
         reset_state();
      endfunction

      function void reset_state();
         head_ptr   = '0;
         fill       = '0;
         idle_count = '0;
         idle_armed = 1'b0;
         data_mode  = DM_IGNORE;
         flush_en   = 1'b0;
         timeout    = TIMEOUT_RESET;
         due_beats.delete();
      endfunction

      function int pending();
         return due_beats.size();
      endfunction

      // register write side effects
      function void write_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DAT_W-1:0] wdata);
         case (idx)
            CSR_DATA_MODE: begin
               data_mode = wdata[MODE_W-1:0];
               if (data_mode == DM_BUFFER) begin
                  fill     = '0;
                  head_ptr = '0;
               end else if (data_mode == DM_PASS) begin
                  flush_en = 1'b0;
               end
            end
            CSR_FLUSH_EN: flush_en = wdata[0];
            CSR_TIMEOUT:  timeout  = wdata[TIMEOUT_W-1:0];
            default: ;
         endcase
      endfunction

      // zero timeout or a half-full queue flushes on the next tick
      function void load_idle_timer();
         if (timeout == '0 || fill >= BUF_SIZE)
            idle_count = TIMEOUT_W'(1);
         else
            idle_count = timeout;
         idle_armed = 1'b1;
      endfunction

      // predict the beats caused by one accepted event
      function void note_event(logic [1:0] ev, logic [BYTE_W-1:0] rx);
         rx_beat_type beat;
         int          n;
         int          k;
         case (ev)
            EV_BYTE: begin
               if (data_mode == DM_PASS) begin
                  beat.data  = rx;
                  beat.chunk = 1'b0;
                  beat.last  = 1'b1;
                  due_beats.push_back(beat);
               end else if (data_mode == DM_BUFFER) begin
                  if (fill < QUEUE_CAP) begin
                     store_mirror[PTR_W'(head_ptr + fill)] = rx;
                     fill = fill + 1'b1;
                     if (flush_en && fill <= BUF_SIZE)
                        load_idle_timer();
                  end else begin
                     dropped++;
                  end
               end
            end
            EV_TICK: begin
               if (idle_armed) begin
                  idle_count = idle_count - 1'b1;
                  if (idle_count == '0) begin
                     idle_armed = 1'b0;
                     n = (fill > BUF_SIZE) ? BUF_SIZE : int'(fill);
                     for (k = 0; k < n; k++) begin
                        beat.data  = store_mirror[PTR_W'(head_ptr + k)];
                        beat.chunk = 1'b1;
                        beat.last  = (k == n - 1);
                        due_beats.push_back(beat);
                     end
                     if (n > 0)
                        chunks++;
                     head_ptr = PTR_W'(head_ptr + n);
                     fill     = fill - FILL_W'(n);
                     if (fill != '0)
                        load_idle_timer();
                  end
               end
            end
            EV_CLEAR: begin
               fill     = '0;
               head_ptr = '0;
            end
            default: ;
         endcase
      endfunction

      // compare one delivered beat with the oldest owed beat
      function void check_delivery(logic [BYTE_W-1:0] data, logic chunk, logic last);
         rx_beat_type want;
         delivered++;
         if (due_beats.size() == 0) begin
            if (mismatches < 10)
               $display("unexpected beat: byte %02h chunk %b last %b", data, chunk, last);
            mismatches++;
            return;
         end
         want = due_beats.pop_front();
         if (want.chunk)
            chunk_beats++;
         if (want.data !== data || want.chunk !== chunk || want.last !== last) begin
            if (mismatches < 10)
               $display({"beat mismatch: want byte %02h chunk %b last %b, ",
                         "got byte %02h chunk %b last %b"},
                        want.data, want.chunk, want.last, data, chunk, last);
            mismatches++;
         end
      endfunction
   endclass

endpackage

>>> tb/tb_uart_rx_idle_timeout_chunker.sv
// ----------------------------------------------------------------------------
// tb_uart_rx_idle_timeout_chunker
// Self-checking bench for the receive chunker: directed events for the mode
// corners, a queue-full burst, then random phases of byte bursts, ticks and
// clears under changing registers, with random idling on both channels.
// ----------------------------------------------------------------------------
module tb_uart_rx_idle_timeout_chunker import urx_pkg::*, urx_tb_pkg::*;;
   timeunit 1ns;
   timeprecision 1ps;

   // codes left unused by the block
   localparam logic [1:0]           EV_SPARE  = 2'd3;
   localparam logic [MODE_W-1:0]    DM_SPARE  = MODE_W'(3);
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE = CSR_IDX_W'(3);

   localparam int QUIET_CYCLES = 16;
   localparam int ITEM_TARGET  = 460;
   localparam int FULL_BURST   = QUEUE_CAP + 4;

   logic                 clock       = 1'b0;
   logic                 reset       = 1'b1;
   logic                 req_valid   = 1'b0;
   logic                 req_ready;
   logic [1:0]           req_mode    = EV_BYTE;
   logic [BYTE_W-1:0]    req_rx_byte = '0;
   logic                 rsp_valid;
   logic                 rsp_ready   = 1'b0;
   logic [BYTE_W-1:0]    rsp_out_byte;
   logic                 rsp_is_chunk;
   logic                 rsp_last;
   logic                 csr_we      = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index   = '0;
   logic [CSR_DAT_W-1:0] csr_wdata   = '0;

   rx_delivery_scoreboard sb = new();
   bit no_idle    = 1'b0;
   int items_sent = 0;
   int live_items = 0;
   int phases     = 0;

   uart_rx_idle_timeout_chunker u_top (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_mode     (req_mode),
      .req_rx_byte  (req_rx_byte),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_out_byte (rsp_out_byte),
      .rsp_is_chunk (rsp_is_chunk),
      .rsp_last     (rsp_last),
      .csr_we       (csr_we),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata)
   );

   // 2 ns clock
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // run limit
   initial begin
      #1_000_000;
      $display("[FAIL] regression broken");
      $finish;
   end

   function automatic int draw_wait();
      return no_idle ? 0 : $urandom_range(0, 12);
   endfunction

   // one event beat on the request channel
   task automatic send_event(logic [1:0] ev, logic [BYTE_W-1:0] rx);
      int gap;
      gap = draw_wait();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_mode    <= ev;
      req_rx_byte <= rx;
      do @(posedge clock); while (!req_ready);
      // bytes dropped outside pass and buffer modes and spare events do not count as work
      if (ev != EV_SPARE &&
          !(ev == EV_BYTE && sb.data_mode != DM_PASS && sb.data_mode != DM_BUFFER))
         live_items++;
      sb.note_event(ev, rx);
      items_sent++;
   endtask

   // hold the sender until every owed beat is delivered and the block settles
   task automatic drain_results();
      req_valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (QUIET_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(logic [CSR_IDX_W-1:0] idx, logic [CSR_DAT_W-1:0] wdata);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= wdata;
      @(posedge clock);
      sb.write_reg(idx, wdata);
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   // mode corners, timer corners, clear and unused codes
   task automatic run_directed();
      // ignore mode after reset
      send_event(EV_BYTE, 8'h00);
      send_event(EV_BYTE, 8'hFF);
      send_event(EV_TICK, 8'h5A);
      send_event(EV_CLEAR, 8'hA5);
      send_event(EV_SPARE, 8'hFF);
      drain_results();
      // per-byte delivery
      csr_write(CSR_DATA_MODE, CSR_DAT_W'(DM_PASS));
      send_event(EV_BYTE, 8'h00);
      send_event(EV_BYTE, 8'hFF);
      send_event(EV_BYTE, 8'hA5);
      drain_results();
      // zero timeout flushes on the first tick
      csr_write(CSR_DATA_MODE, CSR_DAT_W'(DM_BUFFER));
      csr_write(CSR_FLUSH_EN, CSR_DAT_W'(1));
      csr_write(CSR_TIMEOUT, CSR_DAT_W'(0));
      send_event(EV_BYTE, 8'h5A);
      send_event(EV_TICK, 8'h00);
      drain_results();
      // two-tick timeout, two-byte chunk
      csr_write(CSR_TIMEOUT, CSR_DAT_W'(2));
      send_event(EV_BYTE, 8'h01);
      send_event(EV_BYTE, 8'h80);
      send_event(EV_TICK, 8'hFF);
      send_event(EV_TICK, 8'h00);
      // clear while armed, timer then expires on an empty queue
      send_event(EV_BYTE, 8'h33);
      send_event(EV_CLEAR, 8'h00);
      send_event(EV_TICK, 8'h00);
      send_event(EV_TICK, 8'h00);
      // armed timer keeps flushing after leaving buffer mode
      send_event(EV_BYTE, 8'h44);
      send_event(EV_BYTE, 8'h55);
      drain_results();
      csr_write(CSR_DATA_MODE, CSR_DAT_W'(DM_IGNORE));
      send_event(EV_TICK, 8'h00);
      send_event(EV_TICK, 8'h00);
      drain_results();
      // unknown register index and unused data mode
      csr_write(CSR_SPARE, CSR_DAT_W'(16'hFFFF));
      csr_write(CSR_DATA_MODE, CSR_DAT_W'(DM_SPARE));
      send_event(EV_BYTE, 8'h77);
      drain_results();
   endtask

   // fill past capacity: half-full timer load, full chunks, dropped bytes
   task automatic run_full_queue();
      csr_write(CSR_DATA_MODE, CSR_DAT_W'(DM_BUFFER));
      csr_write(CSR_FLUSH_EN, CSR_DAT_W'(1));
      csr_write(CSR_TIMEOUT, CSR_DAT_W'(16'hFFFF));
      repeat (FULL_BURST) send_event(EV_BYTE, BYTE_W'($urandom));
      repeat (2) send_event(EV_TICK, BYTE_W'($urandom));
      drain_results();
   endtask

   // random registers, then random byte bursts and ticks mixed with clears, spare events and drains
   task automatic run_random_phase();
      logic [MODE_W-1:0]    dm;
      logic [TIMEOUT_W-1:0] tmo;
      logic                 fe;
      int                   pick;
      int                   n;
      int                   goal;
      int                   eff;
      phases++;
      no_idle = ($urandom_range(0, 3) == 0);
      pick = $urandom_range(0, 9);
      dm = (pick == 0) ? DM_IGNORE : (pick == 1) ? DM_SPARE :
           (pick < 4) ? DM_PASS : DM_BUFFER;
      fe = ($urandom_range(0, 3) != 0);
      pick = $urandom_range(0, 9);
      tmo = (pick < 6) ? TIMEOUT_W'($urandom_range(0, 6)) :
            (pick < 9) ? TIMEOUT_W'($urandom_range(7, 40)) : TIMEOUT_W'($urandom);
      // write order matters: a pass-mode write clears the flush enable
      if ($urandom_range(0, 1)) begin
         csr_write(CSR_FLUSH_EN, CSR_DAT_W'(fe));
         csr_write(CSR_DATA_MODE, CSR_DAT_W'(dm));
      end else begin
         csr_write(CSR_DATA_MODE, CSR_DAT_W'(dm));
         csr_write(CSR_FLUSH_EN, CSR_DAT_W'(fe));
      end
      csr_write(CSR_TIMEOUT, tmo);
      if ($urandom_range(0, 7) == 0)
         csr_write(CSR_SPARE, CSR_DAT_W'($urandom));
      eff  = (tmo == '0) ? 1 : int'(tmo);
      goal = items_sent + $urandom_range(20, 50);
      while (items_sent < goal) begin
         pick = $urandom_range(0, 19);
         if (pick < 10) begin
            n = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 70) : $urandom_range(1, 10);
            repeat (n) send_event(EV_BYTE, BYTE_W'($urandom));
         end else if (pick < 16) begin
            n = (eff > 40) ? $urandom_range(1, 5) : eff + $urandom_range(0, 2);
            repeat (n) send_event(EV_TICK, BYTE_W'($urandom));
         end else if (pick == 16) begin
            send_event(EV_CLEAR, BYTE_W'($urandom));
         end else if (pick == 17) begin
            send_event(EV_SPARE, BYTE_W'($urandom));
         end else if (pick == 18) begin
            send_event(EV_TICK, BYTE_W'($urandom));
         end else begin
            drain_results();
         end
      end
      drain_results();
   endtask

   // result channel: random stall before each beat
   initial begin
      int stall;
      do @(posedge clock); while (reset);
      forever begin
         stall = draw_wait();
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
         sb.check_delivery(rsp_out_byte, rsp_is_chunk, rsp_last);
      end
   end

   // main sequence
   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      run_directed();
      run_full_queue();
      while (items_sent < ITEM_TARGET)
         run_random_phase();
      drain_results();
      $display("covered %0d events (%0d acting) over %0d random phases",
               items_sent, live_items, phases);
      $display("delivered %0d beats, %0d in %0d chunks, %0d bytes dropped, %0d mismatches",
               sb.delivered, sb.chunk_beats, sb.chunks, sb.dropped, sb.mismatches);
      if (sb.mismatches == 0 && sb.pending() == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule
